// ===== hw/rtl/tbs_pkg.sv =====
`timescale 1ns / 1ps

package tbs_pkg;

    localparam int ID_W      = 8;
    localparam int LEN_W     = 16;
    localparam int RATE_W    = 24;
    localparam int BASE_W    = 16;
    localparam int BLIM_W    = 21;
    localparam int MLIM_W    = 6;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MSG_LIMIT   = 2'd3;

    localparam logic [RATE_W-1:0] RST_TOKEN_RATE  = 24'd256;
    localparam logic [BASE_W-1:0] RST_BUCKET_BASE = 16'd1;
    localparam logic [BLIM_W-1:0] RST_BYTE_LIMIT  = 21'd0;
    localparam logic [MLIM_W-1:0] RST_MSG_LIMIT   = 6'd30;

    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_SENT = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    typedef struct packed {
        logic             op;
        logic [ID_W-1:0]  msg_id;
        logic [LEN_W-1:0] msg_len;
    } t_in;

    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  out_id;
        logic [LEN_W-1:0] out_len;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [RATE_W-1:0] token_rate;
        logic [BASE_W-1:0] bucket_base;
        logic [BLIM_W-1:0] queue_byte_limit;
        logic [MLIM_W-1:0] queue_msg_limit;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REFILL,
        ST_HEAD,
        ST_FLUSH
    } t_state;

endpackage

// ===== hw/rtl/tbs_ram.sv =====
`timescale 1ns / 1ps

module tbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tbs_engine.sv =====
`timescale 1ns / 1ps

module tbs_engine #(
    parameter int QUEUE_DEPTH = 32,
    parameter int FRAC_BITS   = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tbs_pkg::t_cfg i_cfg,
    input  logic          i_tok_load,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tbs_pkg::t_in  i_in,
    input  logic          i_out_free,
    output logic          o_push,
    output tbs_pkg::t_out o_push_data
);

    import tbs_pkg::*;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int BYTES_W = LEN_W + CNT_W;
    localparam int TOK_W   = LEN_W + FRAC_BITS;
    localparam int ENT_W   = ID_W + LEN_W;
    localparam int LIM_W   = ((CNT_W > MLIM_W) ? CNT_W : MLIM_W) + 1;
    localparam int BSUM_W  = ((BYTES_W > BLIM_W) ? BYTES_W : BLIM_W) + 1;
    localparam int TSUM_W  = ((TOK_W > RATE_W) ? TOK_W : RATE_W) + 1;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_state             r_state, n_state;
    logic               r_op, n_op;
    logic [ID_W-1:0]    r_id, n_id;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [TOK_W-1:0]   r_tokens, n_tokens;
    logic               r_pend_v, n_pend_v;
    t_out               r_pend, n_pend;

    logic               mem_we;
    logic [ENT_W-1:0]   rd_data;
    logic [ID_W-1:0]    head_id;
    logic [LEN_W-1:0]   head_len;
    logic [LIM_W-1:0]   lim;
    logic               at_lim;
    logic [BSUM_W-1:0]  blim;
    logic               over_bytes;
    logic               drop_now;
    logic [TOK_W-1:0]   need;
    logic               send_now;
    logic [LEN_W-1:0]   base_eff;
    logic [LEN_W-1:0]   cap_len;
    logic [TOK_W-1:0]   cap;
    logic [TSUM_W-1:0]  tok_sum;
    logic [TOK_W-1:0]   tok_fill;
    logic               take;
    logic               room;
    logic [PTR_W-1:0]   head_next;
    logic [PTR_W-1:0]   tail_next;

    tbs_ram #(
        .WIDTH(ENT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_tail),
        .i_wdata({r_id, r_len}),
        .i_raddr(n_head),
        .o_rdata(rd_data)
    );

    assign head_id  = rd_data[ENT_W-1:LEN_W];
    assign head_len = rd_data[LEN_W-1:0];

    assign lim = (LIM_W'(i_cfg.queue_msg_limit) > LIM_W'(QUEUE_DEPTH))
               ? LIM_W'(QUEUE_DEPTH) : LIM_W'(i_cfg.queue_msg_limit);
    assign at_lim = LIM_W'(r_count) >= lim;

    assign blim = (BSUM_W'(i_cfg.queue_byte_limit) > BSUM_W'(r_len))
                ? BSUM_W'(i_cfg.queue_byte_limit) : BSUM_W'(r_len);
    assign over_bytes = (BSUM_W'(r_bytes) + BSUM_W'(r_len)) > blim;
    assign drop_now   = (r_count != '0) && (at_lim || over_bytes);

    assign need     = TOK_W'(head_len) << FRAC_BITS;
    assign send_now = (r_count != '0) && (r_tokens >= need);

    assign base_eff = (i_cfg.bucket_base == '0) ? LEN_W'(1) : LEN_W'(i_cfg.bucket_base);
    assign cap_len  = ((r_count != '0) && (head_len > base_eff)) ? head_len : base_eff;
    assign cap      = TOK_W'(cap_len) << FRAC_BITS;
    assign tok_sum  = TSUM_W'(r_tokens) + TSUM_W'(i_cfg.token_rate);
    assign tok_fill = (tok_sum > TSUM_W'(cap)) ? cap : tok_sum[TOK_W-1:0];

    assign take      = (r_op == OP_ENQ) ? drop_now : send_now;
    assign room      = !r_pend_v || i_out_free;
    assign head_next = (r_head == LAST_PTR) ? '0 : r_head + PTR_W'(1);
    assign tail_next = (r_tail == LAST_PTR) ? '0 : r_tail + PTR_W'(1);

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_bytes  <= '0;
            r_tokens <= TOK_W'(1) << FRAC_BITS;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_tokens <= n_tokens;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_id   <= n_id;
        r_len  <= n_len;
        r_pend <= n_pend;
    end

    always_comb begin
        n_state          = r_state;
        n_op             = r_op;
        n_id             = r_id;
        n_len            = r_len;
        n_head           = r_head;
        n_tail           = r_tail;
        n_count          = r_count;
        n_bytes          = r_bytes;
        n_tokens         = r_tokens;
        n_pend_v         = r_pend_v;
        n_pend           = r_pend;
        mem_we           = 1'b0;
        o_push           = 1'b0;
        o_push_data      = r_pend;
        o_push_data.last = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_in.op;
                    n_id    = i_in.msg_id;
                    n_len   = i_in.msg_len;
                    n_state = (i_in.op == OP_TICK) ? ST_REFILL : ST_HEAD;
                end
            end
            ST_REFILL: begin
                n_tokens = tok_fill;
                n_state  = ST_HEAD;
            end
            ST_HEAD: begin
                if (take) begin
                    if (room) begin
                        o_push         = r_pend_v;
                        n_pend_v       = 1'b1;
                        n_pend.kind    = (r_op == OP_ENQ) ? KIND_DROP : KIND_SENT;
                        n_pend.out_id  = head_id;
                        n_pend.out_len = head_len;
                        n_pend.last    = 1'b0;
                        n_head         = head_next;
                        n_count        = r_count - CNT_W'(1);
                        n_bytes        = r_bytes - BYTES_W'(head_len);
                        if (r_op == OP_TICK) begin
                            n_tokens = r_tokens - need;
                        end
                    end
                end else begin
                    if (r_op == OP_ENQ) begin
                        mem_we  = 1'b1;
                        n_tail  = tail_next;
                        n_count = r_count + CNT_W'(1);
                        n_bytes = r_bytes + BYTES_W'(r_len);
                    end
                    n_state = r_pend_v ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (i_out_free) begin
                    o_push           = 1'b1;
                    o_push_data.last = 1'b1;
                    n_pend_v         = 1'b0;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_tok_load) begin
            n_tokens = TOK_W'(base_eff) << FRAC_BITS;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_out_free)
        else $error("push into a full output register");

    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> r_pend_v)
        else $error("flush without a pending result");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending result left while idle");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (r_state == ST_FLUSH)) |=> (r_state == ST_IDLE) && !r_pend_v)
        else $error("flush did not close the transaction");

endmodule

// ===== hw/rtl/token_bucket_shaper_drop_oldest_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_stall      i_in  (op, msg_id, msg_len)
// out       output     o_out_valid / i_out_stall    o_out (kind, out_id, out_len, last)
// cfg       input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
// Enqueue: drop D oldest head entries, write the new one, then flush if D > 0.
// Tick: refill tokens, send S head entries while tokens last, then flush if S > 0.
// One RAM read per cycle; a head entry drops or sends per cycle unless output stalls.
// Reset is synchronous: queue empty, tokens at one byte, registers at their defaults.
// A stalled output holds the engine; the input stalls until the current transaction ends.

module token_bucket_shaper_drop_oldest_unit #(
    parameter int QUEUE_DEPTH = 32,
    parameter int FRAC_BITS   = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  tbs_pkg::t_in                    i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output tbs_pkg::t_out                   o_out,
    input  logic                            i_cfg_we,
    input  logic [tbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tbs_pkg::CFG_W-1:0]       i_cfg_data
);

    import tbs_pkg::*;

    t_cfg r_cfg;
    logic r_tok_load;
    logic r_out_valid;
    t_out r_out;
    logic out_free;
    logic push;
    t_out push_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.token_rate       <= RST_TOKEN_RATE;
            r_cfg.bucket_base      <= RST_BUCKET_BASE;
            r_cfg.queue_byte_limit <= RST_BYTE_LIMIT;
            r_cfg.queue_msg_limit  <= RST_MSG_LIMIT;
            r_tok_load             <= 1'b0;
        end else begin
            r_tok_load <= i_cfg_we && (i_cfg_idx == CFG_BUCKET_BASE);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TOKEN_RATE:  r_cfg.token_rate       <= i_cfg_data[RATE_W-1:0];
                    CFG_BUCKET_BASE: r_cfg.bucket_base      <= i_cfg_data[BASE_W-1:0];
                    CFG_BYTE_LIMIT:  r_cfg.queue_byte_limit <= i_cfg_data[BLIM_W-1:0];
                    CFG_MSG_LIMIT:   r_cfg.queue_msg_limit  <= i_cfg_data[MLIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= push_data;
        end
    end

    tbs_engine #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_tok_load (r_tok_load),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_out_free (out_free),
        .o_push     (push),
        .o_push_data(push_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tbs_pkg::*;

    localparam int QDEPTH      = 32;
    localparam int FRAC        = 8;
    localparam int BY_MODEL    = -1;
    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 45;
    localparam int HOLD_PHASE  = 1;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 12;
    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        t_in                  item;
        int                   n_typed;
        t_out                 typed;
    } t_plan_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    // shaper state as predicted
    logic [RATE_W-1:0] rate_r;
    logic [BASE_W-1:0] base_r;
    logic [BLIM_W-1:0] byte_cap_r;
    logic [MLIM_W-1:0] msg_cap_r;
    logic [ID_W-1:0]   slot_id [QDEPTH];
    logic [LEN_W-1:0]  slot_len [QDEPTH];
    int unsigned       head_idx;
    int unsigned       tail_idx;
    int unsigned       depth_cnt;
    int unsigned       queued_sum;
    longint unsigned   bucket;

    t_out      burst_q[$];
    t_out      due_q[$];
    t_plan_row plan_q[$];

    int   err_cnt = 0;
    int   quiet_cycles = 0;
    bit   typed_on;
    int   typed_n;
    t_out typed_res;
    bit   calm;
    bit   rx_hold_req;

    token_bucket_shaper_drop_oldest_unit #(
        .QUEUE_DEPTH(QDEPTH),
        .FRAC_BITS  (FRAC)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned base_eff();
        return (base_r == '0) ? 64'd1 : 64'(base_r);
    endfunction

    function automatic t_out head_result(input logic kind);
        t_out r;
        r.kind    = kind;
        r.out_id  = slot_id[head_idx];
        r.out_len = slot_len[head_idx];
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic void pop_head();
        queued_sum -= 32'(slot_len[head_idx]);
        head_idx = (head_idx + 1) % QDEPTH;
        depth_cnt--;
    endfunction

    function automatic void shape_item(input t_in x);
        longint unsigned cap;
        longint unsigned need;
        int unsigned     lim;
        int unsigned     room;
        t_out            r;
        burst_q.delete();
        if (x.op == OP_ENQ) begin
            lim  = (32'(msg_cap_r) > QDEPTH) ? QDEPTH : 32'(msg_cap_r);
            room = (32'(byte_cap_r) > 32'(x.msg_len)) ? 32'(byte_cap_r) : 32'(x.msg_len);
            while (depth_cnt > 0 &&
                   (depth_cnt >= lim || queued_sum + 32'(x.msg_len) > room)) begin
                burst_q.push_back(head_result(KIND_DROP));
                pop_head();
            end
            slot_id[tail_idx]  = x.msg_id;
            slot_len[tail_idx] = x.msg_len;
            tail_idx = (tail_idx + 1) % QDEPTH;
            depth_cnt++;
            queued_sum += 32'(x.msg_len);
        end else begin
            cap = base_eff();
            if (depth_cnt > 0 && 64'(slot_len[head_idx]) > cap) cap = 64'(slot_len[head_idx]);
            cap = cap << FRAC;
            bucket += 64'(rate_r);
            if (bucket > cap) bucket = cap;
            while (depth_cnt > 0) begin
                need = 64'(slot_len[head_idx]) << FRAC;
                if (bucket < need) break;
                bucket -= need;
                burst_q.push_back(head_result(KIND_SENT));
                pop_head();
            end
        end
        if (burst_q.size() > 0) begin
            r = burst_q.pop_back();
            r.last = 1'b1;
            burst_q.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            rate_r     = RST_TOKEN_RATE;
            base_r     = RST_BUCKET_BASE;
            byte_cap_r = RST_BYTE_LIMIT;
            msg_cap_r  = RST_MSG_LIMIT;
            head_idx   = 0;
            tail_idx   = 0;
            depth_cnt  = 0;
            queued_sum = 0;
            bucket     = base_eff() << FRAC;
        end else begin
            quiet_cycles++;
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                if (due_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected transaction: kind=%0d id=%02h len=%0d last=%0d",
                                 o_out.kind, o_out.out_id, o_out.out_len, o_out.last);
                end else begin
                    want = due_q[0];
                    due_q.delete(0);
                    if (o_out.kind !== want.kind || o_out.out_id !== want.out_id ||
                        o_out.out_len !== want.out_len || o_out.last !== want.last) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("mismatch: expected kind=%0d id=%02h len=%0d last=%0d",
                                     want.kind, want.out_id, want.out_len, want.last);
                            $display("          got      kind=%0d id=%02h len=%0d last=%0d",
                                     o_out.kind, o_out.out_id, o_out.out_len, o_out.last);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                quiet_cycles = 0;
                case (i_cfg_idx)
                    CFG_TOKEN_RATE: rate_r = i_cfg_data[RATE_W-1:0];
                    CFG_BUCKET_BASE: begin
                        base_r = i_cfg_data[BASE_W-1:0];
                        bucket = base_eff() << FRAC;
                    end
                    CFG_BYTE_LIMIT: byte_cap_r = i_cfg_data[BLIM_W-1:0];
                    CFG_MSG_LIMIT: msg_cap_r = i_cfg_data[MLIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                quiet_cycles = 0;
                shape_item(i_in);
                if (typed_on) begin
                    for (int k = 0; k < typed_n; k++) due_q.push_back(typed_res);
                end else begin
                    foreach (burst_q[k]) due_q.push_back(burst_q[k]);
                end
            end
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        int span;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                span = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                span = $urandom_range(1, 30);
                i_out_stall <= 1'b0;
            end else begin
                span = $urandom_range(1, 15);
                i_out_stall <= 1'b1;
            end
            repeat (span - 1) @(negedge i_clk);
        end
    end

    task automatic send_item(input t_in x);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (due_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
        t_plan_row row;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.item    = '0;
        row.n_typed = 0;
        row.typed   = '0;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_item(input logic op, input logic [ID_W-1:0] id,
                                      input logic [LEN_W-1:0] len, input int n_typed,
                                      input t_out typed = '0);
        t_plan_row row;
        row.is_reg       = 1'b0;
        row.reg_idx      = '0;
        row.reg_val      = '0;
        row.item.op      = op;
        row.item.msg_id  = id;
        row.item.msg_len = len;
        row.n_typed      = n_typed;
        row.typed        = typed;
        plan_q.push_back(row);
    endfunction

    initial begin
        t_in              x;
        t_plan_row        row;
        logic [CFG_W-1:0] v;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        typed_on    = 1'b0;
        typed_n     = 0;
        typed_res   = '0;
        calm        = 1'b0;
        rx_hold_req = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default registers: byte limit zero, so each enqueue drops what is queued
        plan_item(OP_ENQ,  8'h00, 16'h0001, 0);
        plan_item(OP_ENQ,  8'hFF, 16'hFFFF, 1, t_out'{KIND_DROP, 8'h00, 16'h0001, 1'b1});
        plan_item(OP_TICK, 8'h00, 16'h0000, 0);
        plan_item(OP_ENQ,  8'h5A, 16'h0000, 1, t_out'{KIND_DROP, 8'hFF, 16'hFFFF, 1'b1});
        plan_item(OP_TICK, 8'hA5, 16'hFFFF, 1, t_out'{KIND_SENT, 8'h5A, 16'h0000, 1'b1});
        plan_item(OP_TICK, 8'h00, 16'h0000, 0);
        plan_reg(CFG_BYTE_LIMIT, 24'h1FFFFF);
        plan_reg(CFG_MSG_LIMIT, 24'd0);
        plan_item(OP_ENQ,  8'h01, 16'd100, 0);
        plan_item(OP_ENQ,  8'h02, 16'd200, 1, t_out'{KIND_DROP, 8'h01, 16'd100, 1'b1});
        plan_reg(CFG_MSG_LIMIT, 24'd63);
        plan_reg(CFG_BUCKET_BASE, 24'd0);
        plan_reg(CFG_TOKEN_RATE, 24'hFFFFFF);
        plan_item(OP_ENQ,  8'h03, 16'hFFFF, BY_MODEL);
        plan_item(OP_ENQ,  8'h04, 16'h8000, BY_MODEL);
        plan_item(OP_TICK, 8'h00, 16'h0000, BY_MODEL);
        plan_item(OP_TICK, 8'h00, 16'h0000, BY_MODEL);
        plan_item(OP_TICK, 8'h00, 16'h0000, BY_MODEL);
        plan_reg(CFG_TOKEN_RATE, 24'd0);
        plan_item(OP_ENQ,  8'h96, 16'h0001, BY_MODEL);
        plan_item(OP_TICK, 8'h00, 16'h0000, BY_MODEL);
        plan_reg(CFG_BUCKET_BASE, 24'h00FFFF);
        plan_item(OP_TICK, 8'h00, 16'h0000, BY_MODEL);
        plan_reg(CFG_MSG_LIMIT, 24'd1);
        plan_item(OP_ENQ,  8'h6C, 16'h1234, BY_MODEL);
        plan_item(OP_ENQ,  8'h33, 16'h0001, BY_MODEL);
        plan_item(OP_TICK, 8'h00, 16'h0000, BY_MODEL);

        foreach (plan_q[i]) begin
            row = plan_q[i];
            if (row.is_reg) begin
                wait_idle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                typed_on  = (row.n_typed != BY_MODEL);
                typed_n   = row.n_typed;
                typed_res = row.typed;
                send_item(row.item);
                typed_on  = 1'b0;
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = CFG_W'({BASE_W{1'b1}});
                default: v = CFG_W'($urandom_range(1, 600));
            endcase
            write_reg(CFG_BUCKET_BASE, v);
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = {RATE_W{1'b1}};
                default: v = CFG_W'($urandom_range(0, 400 * 256));
            endcase
            write_reg(CFG_TOKEN_RATE, v);
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = CFG_W'({BLIM_W{1'b1}});
                default: v = CFG_W'($urandom_range(1, 3000));
            endcase
            if (ph == HOLD_PHASE) v = '0;
            write_reg(CFG_BYTE_LIMIT, v);
            case ($urandom_range(0, 7))
                0: v = '0;
                1: v = 24'd63;
                2: v = 24'd32;
                3: v = 24'd1;
                4, 5: v = CFG_W'($urandom_range(0, 63));
                default: v = CFG_W'($urandom_range(2, 10));
            endcase
            write_reg(CFG_MSG_LIMIT, v);
            if (ph == HOLD_PHASE) rx_hold_req = 1'b1;
            if (ph == N_PHASES - 1) calm = 1'b1;
            repeat (PHASE_ITEMS) begin
                x.op     = ($urandom_range(0, 9) < 4) ? OP_TICK : OP_ENQ;
                x.msg_id = ID_W'($urandom_range(0, 255));
                case ($urandom_range(0, 15))
                    0: x.msg_len = '0;
                    1, 2: x.msg_len = LEN_W'($urandom_range(0, 65535));
                    default: x.msg_len = LEN_W'($urandom_range(1, 300));
                endcase
                send_item(x);
            end
        end

        i_in_valid <= 1'b0;
        while (due_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE * 3) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
